// File: design/gwm_pkg.sv
// Shared constants, types and functions of the glob wildcard matcher.
package gwm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int MAX_RANGES  = 4;

    localparam int ACT_W  = MAX_PATTERN + 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int PLEN_W = 6;
    localparam int POS_W  = 5;
    localparam int SLOT_W = 2;
    localparam int CHR_W  = 7;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_CHAR = 2'd1,
        OP_END  = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_STAR    = 2'd2,
        KIND_SET     = 2'd3
    } kind_e;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        kind_e             kind;
        logic [CHR_W-1:0]  lo;
        logic [CHR_W-1:0]  hi;
    } cell_load_t;

    typedef struct packed {
        logic load_en;
        logic act_wr;
        logic act_val;
        logic act_rst;
        logic in_use;
    } cell_ctrl_t;

    // Propagate activity through star positions (parallel prefix).
    function automatic logic [ACT_W-1:0] close_stars(input logic [ACT_W-1:0] act,
                                                     input logic [MAX_PATTERN-1:0] star);
        logic [ACT_W-1:0] g;
        logic [ACT_W-1:0] p;
        logic [ACT_W-1:0] g_n;
        logic [ACT_W-1:0] p_n;
        g = act;
        p = {star, 1'b0};
        for (int d = 1; d < ACT_W; d = d * 2) begin
            g_n = g;
            p_n = p;
            for (int j = d; j < ACT_W; j++) begin
                g_n[j] = g[j] | (p[j] & g[j-d]);
                p_n[j] = p[j] & p[j-d];
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

endpackage

// File: design/gwm_cell.sv
// One pattern position: element kind, its character ranges and its active bit.
module gwm_cell
    import gwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  cell_load_t        load,
    input  logic [BYTE_W-1:0] character,
    input  logic              act_closed,
    input  logic              adv_in,
    output logic              adv_out,
    output logic              raw_next,
    output logic              star_eff,
    output logic              act_q
);

    kind_e                  kind_reg;
    logic [CHR_W-1:0]       lo_reg    [MAX_RANGES];
    logic [CHR_W-1:0]       hi_reg    [MAX_RANGES];
    logic [MAX_RANGES-1:0]  valid_reg;
    logic [MAX_RANGES-1:0]  valid_next;
    logic                   act_reg;
    logic [MAX_RANGES-1:0]  slot_hit;
    logic                   in_set;
    logic                   is_star;
    logic                   is_one;

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            kind_reg          <= load.kind;
            lo_reg[load.slot] <= load.lo;
            hi_reg[load.slot] <= load.hi;
        end
    end

    always_comb begin
        if (load.slot == '0) begin
            valid_next = MAX_RANGES'(1);
        end else begin
            valid_next = valid_reg | (MAX_RANGES'(1) << load.slot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            act_reg   <= ctrl.act_rst;
        end else begin
            if (ctrl.load_en) begin
                valid_reg <= valid_next;
            end
            if (ctrl.act_wr) begin
                act_reg <= ctrl.act_val;
            end
        end
    end

    always_comb begin
        for (int s = 0; s < MAX_RANGES; s++) begin
            slot_hit[s] = valid_reg[s] && ({1'b0, lo_reg[s]} <= character)
                          && (character <= {1'b0, hi_reg[s]});
        end
    end

    assign in_set   = |slot_hit;
    assign is_star  = (kind_reg == KIND_STAR);
    assign is_one   = (kind_reg == KIND_ONE);
    assign star_eff = is_star & ctrl.in_use;
    assign adv_out  = ctrl.in_use & act_closed & ~is_star & (is_one | in_set);
    assign raw_next = (ctrl.in_use & act_closed & is_star) | adv_in;
    assign act_q    = act_reg;

endmodule

// File: design/gwm_out_buf.sv
// Two-entry result buffer between the matcher and the result channel.
module gwm_out_buf
    import gwm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  logic push_data,
    input  logic m_ready,
    output logic m_valid,
    output logic m_matched,
    output logic full
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       head_reg;
    logic       tail_reg;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) & m_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push && cnt_reg == 2'd0) begin
            head_reg <= push_data;
        end
        if (push && ((cnt_reg == 2'd1 && !pop) || (cnt_reg == 2'd2 && pop))) begin
            tail_reg <= push_data;
        end
    end

    assign m_valid   = (cnt_reg != 2'd0);
    assign m_matched = head_reg;
    assign full      = (cnt_reg == 2'd2);

endmodule

// File: design/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher: APB register, cell row and result buffer.
//
// Usage:
//   Input channel (s_valid/s_ready): each transfer carries one operation.
//   A load writes one range of the element at s_position; range slot 0 clears
//   the other slots. A name character advances the active-position vector of
//   the pattern by one byte. An end of name produces one result on m_matched
//   and re-arms the matcher for the next name.
//   Result channel (m_valid/m_ready): m_matched is 1 when the whole name
//   matched the whole pattern.
//   Configuration: APB register 0 at byte address 0 holds pattern_length.
//   Throughput: one input transfer per cycle while s_ready is high, loads, characters and ends alike;
//   the star closure is a parallel prefix across the row of cells.
//   Result: an end transfer registers its result in the result buffer, behind any result still waiting.
//   Stall: a two-entry result buffer absorbs results; s_ready drops only while
//   both entries are waiting on m_ready.
//   Reset: synchronous, active low; clears the length, all range valid bits,
//   the result buffer, and arms position 0. Pattern storage keeps its contents.
module glob_wildcard_matcher
    import gwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [POS_W-1:0]  s_position,
    input  logic [SLOT_W-1:0] s_range_slot,
    input  logic [1:0]        s_kind,
    input  logic [CHR_W-1:0]  s_range_low,
    input  logic [CHR_W-1:0]  s_range_high,
    input  logic [BYTE_W-1:0] s_character,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_matched
);

    logic [PLEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]       eff_len;
    logic                   reg_sel;
    logic                   accept;
    logic                   do_load;
    logic                   do_char;
    logic                   do_end;
    logic                   buf_full;
    logic                   act_top_reg;
    logic [ACT_W-1:0]       keep;
    logic [MAX_PATTERN-1:0] in_use;
    logic [MAX_PATTERN-1:0] star_eff;
    logic [MAX_PATTERN-1:0] cell_act;
    logic [MAX_PATTERN-1:0] adv;
    logic [MAX_PATTERN-1:0] raw_cell;
    logic [ACT_W-1:0]       act_cur;
    logic [ACT_W-1:0]       act_closed;
    logic [ACT_W-1:0]       next_closed;
    logic [ACT_W-1:0]       rearm;
    logic [ACT_W-1:0]       act_new;
    logic                   matched_now;
    cell_load_t             load;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {{(32-PLEN_W){1'b0}}, len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            len_reg <= pwdata[PLEN_W-1:0];
        end
    end

    assign eff_len = (len_reg > PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                      : LEN_W'(len_reg);

    always_comb begin
        for (int i = 0; i < ACT_W; i++) begin
            keep[i] = (LEN_W'(i) <= eff_len);
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            in_use[i] = (LEN_W'(i) < eff_len);
        end
    end

    // Operation decode
    assign s_ready = ~buf_full;
    assign accept  = s_valid & s_ready;

    always_comb begin
        do_load = 1'b0;
        do_char = 1'b0;
        do_end  = 1'b0;
        unique case (s_operation)
            OP_LOAD: do_load = accept;
            OP_CHAR: do_char = accept;
            OP_END:  do_end  = accept;
            default: ;
        endcase
    end

    assign load.slot = s_range_slot;
    assign load.kind = kind_e'(s_kind);
    assign load.lo   = s_range_low;
    assign load.hi   = s_range_high;

    // Active vector and star closure
    assign act_cur     = {act_top_reg, cell_act} & keep;
    assign act_closed  = close_stars(act_cur, star_eff);
    assign next_closed = close_stars({adv[MAX_PATTERN-1], raw_cell}, star_eff);
    assign rearm       = close_stars(ACT_W'(1), star_eff);
    assign matched_now = act_closed[eff_len];
    assign act_new     = do_end ? rearm : next_closed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_top_reg <= 1'b0;
        end else if (do_char || do_end) begin
            act_top_reg <= act_new[MAX_PATTERN];
        end
    end

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        cell_ctrl_t ctrl;
        logic       adv_in;

        assign ctrl.load_en = do_load & (s_position == POS_W'(i));
        assign ctrl.act_wr  = do_char | do_end;
        assign ctrl.act_val = act_new[i];
        assign ctrl.act_rst = (i == 0);
        assign ctrl.in_use  = in_use[i];

        if (i == 0) begin : g_first
            assign adv_in = 1'b0;
        end else begin : g_rest
            assign adv_in = adv[i-1];
        end

        gwm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .load       (load),
            .character  (s_character),
            .act_closed (act_closed[i]),
            .adv_in     (adv_in),
            .adv_out    (adv[i]),
            .raw_next   (raw_cell[i]),
            .star_eff   (star_eff[i]),
            .act_q      (cell_act[i])
        );
    end

    gwm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (do_end),
        .push_data (matched_now),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_matched (m_matched),
        .full      (buf_full)
    );

endmodule

// File: design/gwm_checker.sv
// Port-level checks of the glob wildcard matcher and their binding.
module gwm_checker
    import gwm_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_matched
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_matched)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == OP_END) |=> m_valid)
        else $error("end of name transfer gave no result");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);
